// ===== sv/elt_pkg.sv =====
// elt_pkg: types, constants and codes shared by the edge list table
// depends on nothing; used by elt_cell, elt_ctrl and edge_list_table_unit

package elt_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int NODE_W      = 8;
    localparam int TAG_W       = 32;
    localparam int LIMIT_W     = 7;
    localparam int COUNT_W     = 7;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int LIMIT_RESET = 64;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_CHECK    = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_SET_INFO = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic              active;
        req_t              req;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [TAG_W-1:0]  tag;
        logic              ins_ok;
        logic              found;
        logic [TAG_W-1:0]  hit_tag;
        logic [IDX_W-1:0]  idx;
    } wave_t;

endpackage

// ===== sv/elt_cell.sv =====
// elt_cell: one table entry with its compare, insert and shift-down logic
// depends on elt_pkg; chained by edge_list_table_unit

module elt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [elt_pkg::CNT_W-1:0] fill,
    input  elt_pkg::wave_t            wave_in,
    output elt_pkg::wave_t            wave_out,
    input  elt_pkg::entry_t           right_entry,
    input  logic                      right_shift,
    output elt_pkg::entry_t           entry_out,
    output logic                      shift_out
);

    elt_pkg::entry_t entry_reg;
    elt_pkg::entry_t entry_next;
    elt_pkg::wave_t  wave_reg;
    elt_pkg::wave_t  wave_next;
    logic            active_reg;
    logic            active_next;
    logic            occupied;
    logic            hit;
    logic            ins_here;

    always_comb
    begin
        occupied = wave_in.active &&
                   (elt_pkg::CNT_W'(wave_in.idx) < fill);
        hit = occupied && !wave_in.found && (wave_in.req != elt_pkg::REQ_INSERT) &&
              (entry_reg.src == wave_in.src) && (entry_reg.dst == wave_in.dst);
        ins_here = wave_in.active && (wave_in.req == elt_pkg::REQ_INSERT) &&
                   wave_in.ins_ok && (elt_pkg::CNT_W'(wave_in.idx) == fill);
        shift_out = wave_in.active && (wave_in.req == elt_pkg::REQ_REMOVE) &&
                    wave_in.found;

        entry_next = entry_reg;
        if (right_shift)
        begin
            entry_next = right_entry;
        end
        else if (ins_here)
        begin
            entry_next.src = wave_in.src;
            entry_next.dst = wave_in.dst;
            entry_next.tag = wave_in.tag;
        end
        else if (hit && (wave_in.req == elt_pkg::REQ_SET_INFO))
        begin
            entry_next.tag = wave_in.tag;
        end

        wave_next       = wave_in;
        wave_next.idx   = elt_pkg::IDX_W'(wave_in.idx + 1'b1);
        wave_next.found = wave_in.found | hit;
        if (hit)
        begin
            wave_next.hit_tag = (wave_in.req == elt_pkg::REQ_SET_INFO) ?
                                wave_in.tag : entry_reg.tag;
        end
        active_next = wave_in.active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        wave_reg  <= wave_next;
    end

    always_comb
    begin
        wave_out        = wave_reg;
        wave_out.active = active_reg;
    end

    assign entry_out = entry_reg;

endmodule

// ===== sv/elt_ctrl.sv =====
// elt_ctrl: request sequencer, fill count, limit register and result register
// depends on elt_pkg; launches a wave into the cell chain and collects it at the end

module elt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  elt_pkg::req_t               in_req,
    input  logic [elt_pkg::NODE_W-1:0]  in_src,
    input  logic [elt_pkg::NODE_W-1:0]  in_dst,
    input  logic [elt_pkg::TAG_W-1:0]   in_tag,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [elt_pkg::LIMIT_W-1:0] cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output elt_pkg::status_t            out_status,
    output logic [elt_pkg::TAG_W-1:0]   out_tag,
    output logic [elt_pkg::COUNT_W-1:0] out_count,
    output logic [elt_pkg::CNT_W-1:0]   fill,
    output elt_pkg::wave_t              launch,
    input  elt_pkg::wave_t              exit_wave
);

    elt_pkg::state_t                state_reg;
    elt_pkg::state_t                state_next;
    logic [elt_pkg::LIMIT_W-1:0]    limit_reg;
    logic [elt_pkg::CNT_W-1:0]      fill_reg;
    logic [elt_pkg::CNT_W-1:0]      fill_next;
    logic                           launch_active_reg;
    elt_pkg::wave_t                 launch_reg;
    elt_pkg::wave_t                 launch_next;
    elt_pkg::status_t               res_status_reg;
    elt_pkg::status_t               res_status_next;
    logic [elt_pkg::TAG_W-1:0]      res_tag_reg;
    logic [elt_pkg::TAG_W-1:0]      res_tag_next;
    logic                           out_valid_reg;
    elt_pkg::status_t               out_status_reg;
    logic [elt_pkg::TAG_W-1:0]      out_tag_reg;
    logic [elt_pkg::COUNT_W-1:0]    out_count_reg;
    logic [elt_pkg::CMP_W-1:0]      act_limit;
    logic                           full;
    logic                           accept;
    logic                           finish;
    logic                           load_out;

    always_comb
    begin
        act_limit = (elt_pkg::CMP_W'(limit_reg) < elt_pkg::CMP_W'(elt_pkg::CAPACITY)) ?
                    elt_pkg::CMP_W'(limit_reg) : elt_pkg::CMP_W'(elt_pkg::CAPACITY);
        full = elt_pkg::CMP_W'(fill_reg) >= act_limit;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            elt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = elt_pkg::S_RUN;
                end
            end
            elt_pkg::S_RUN:
            begin
                if (exit_wave.active)
                begin
                    state_next = elt_pkg::S_HOLD;
                end
            end
            elt_pkg::S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = elt_pkg::S_IDLE;
                end
            end
            default: state_next = elt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            elt_pkg::S_IDLE: in_ready = 1'b1;
            elt_pkg::S_RUN:  finish   = exit_wave.active;
            elt_pkg::S_HOLD: load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
        accept = in_valid && in_ready;
    end

    always_comb
    begin
        launch_next         = launch_reg;
        launch_next.active  = 1'b0;
        if (accept)
        begin
            launch_next.req     = in_req;
            launch_next.src     = in_src;
            launch_next.dst     = in_dst;
            launch_next.tag     = in_tag;
            launch_next.ins_ok  = !((in_req == elt_pkg::REQ_INSERT) && full);
            launch_next.found   = 1'b0;
            launch_next.hit_tag = '0;
            launch_next.idx     = '0;
        end

        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        if (finish)
        begin
            res_tag_next = exit_wave.found ? exit_wave.hit_tag : '0;
            if (!exit_wave.ins_ok)
            begin
                res_status_next = elt_pkg::STAT_FULL;
            end
            else if (exit_wave.req == elt_pkg::REQ_INSERT)
            begin
                res_status_next = elt_pkg::STAT_DONE;
                fill_next       = elt_pkg::CNT_W'(fill_reg + 1'b1);
            end
            else if (exit_wave.found)
            begin
                res_status_next = elt_pkg::STAT_DONE;
                if (exit_wave.req == elt_pkg::REQ_REMOVE)
                begin
                    fill_next = elt_pkg::CNT_W'(fill_reg - 1'b1);
                end
            end
            else
            begin
                res_status_next = elt_pkg::STAT_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= elt_pkg::S_IDLE;
            limit_reg         <= elt_pkg::LIMIT_W'(elt_pkg::LIMIT_RESET);
            fill_reg          <= '0;
            launch_active_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fill_reg          <= fill_next;
            launch_active_reg <= accept;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        launch_reg     <= launch_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_tag_reg    <= res_tag_reg;
            out_count_reg  <= elt_pkg::COUNT_W'(fill_reg);
        end
    end

    always_comb
    begin
        launch        = launch_reg;
        launch.active = launch_active_reg;
    end

    assign cfg_ready  = 1'b1;
    assign fill       = fill_reg;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_tag    = out_tag_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== sv/edge_list_table_unit.sv =====
// edge_list_table_unit: top level; sequencer plus a chain of CAPACITY entry cells
// depends on elt_pkg, elt_cell and elt_ctrl
// path: the request is registered as a wave that walks the cell chain one cell per
//   cycle; its result is registered in the sequencer and again at the output
// flow: one request in flight at a time; a result not taken holds the next result,
//   and with it the next request, until it is taken
// reset: fill count zero, edge limit 64, entries hold no defined value until written

module edge_list_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [elt_pkg::IN_DATA_W-1:0]  s_tdata,   // src_node, dst_node, info_tag
    input  logic [1:0]                     s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [elt_pkg::OUT_DATA_W-1:0] m_tdata,   // tag_out, entry_count, zero pad
    output logic [1:0]                     m_tuser,   // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [elt_pkg::LIMIT_W-1:0]    cfg_data   // edge_limit
);

    elt_pkg::wave_t              waves   [0:elt_pkg::CAPACITY];
    elt_pkg::entry_t             entries [0:elt_pkg::CAPACITY];
    logic                        shifts  [0:elt_pkg::CAPACITY];
    logic [elt_pkg::CNT_W-1:0]   fill;
    elt_pkg::status_t            out_status;
    logic [elt_pkg::TAG_W-1:0]   out_tag;
    logic [elt_pkg::COUNT_W-1:0] out_count;

    elt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (elt_pkg::req_t'(s_tuser)),
        .in_src     (s_tdata[7:0]),
        .in_dst     (s_tdata[15:8]),
        .in_tag     (s_tdata[47:16]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_tag    (out_tag),
        .out_count  (out_count),
        .fill       (fill),
        .launch     (waves[0]),
        .exit_wave  (waves[elt_pkg::CAPACITY])
    );

    assign entries[elt_pkg::CAPACITY] = '0;
    assign shifts[elt_pkg::CAPACITY]  = 1'b0;

    for (genvar i = 0; i < elt_pkg::CAPACITY; i++)
    begin : g_cell
        elt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .fill        (fill),
            .wave_in     (waves[i]),
            .wave_out    (waves[i+1]),
            .right_entry (entries[i+1]),
            .right_shift (shifts[i+1]),
            .entry_out   (entries[i]),
            .shift_out   (shifts[i])
        );
    end

    assign m_tdata = {{(elt_pkg::OUT_DATA_W - elt_pkg::TAG_W - elt_pkg::COUNT_W){1'b0}},
                      out_count, out_tag};
    assign m_tuser = out_status;

endmodule

// ===== dv/edge_list_table_unit_tb.sv =====
// edge_list_table_unit_tb: self-checking bench for the edge list table, directed rows then random
// phases under a range of edge limits, every result checked against the directed rows or a local table model
// depends on elt_pkg and edge_list_table_unit

module edge_list_table_unit_tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int STYLE_FILL   = 0;
    localparam int STYLE_MIX    = 1;
    localparam int STYLE_DRAIN  = 2;

    typedef struct packed {
        elt_pkg::status_t                 status;
        logic [elt_pkg::TAG_W-1:0]        tag;
        logic [elt_pkg::COUNT_W-1:0]      count;
    } answer_t;

    typedef struct packed {
        logic                             is_cfg;
        logic [elt_pkg::LIMIT_W-1:0]      cfg_val;
        elt_pkg::req_t                    req;
        logic [elt_pkg::NODE_W-1:0]       src;
        logic [elt_pkg::NODE_W-1:0]       dst;
        logic [elt_pkg::TAG_W-1:0]        tag;
        logic                             typed;
        answer_t                          ans;
    } plan_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [elt_pkg::IN_DATA_W-1:0]        s_tdata;    // src_node, dst_node, info_tag
    logic [1:0]                           s_tuser;    // req_type
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [elt_pkg::OUT_DATA_W-1:0]       m_tdata;    // tag_out, entry_count, zero pad
    logic [1:0]                           m_tuser;    // status
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [elt_pkg::LIMIT_W-1:0]          cfg_data;

    // local copy of the edge table
    logic [elt_pkg::NODE_W-1:0]           tbl_src [elt_pkg::CAPACITY];
    logic [elt_pkg::NODE_W-1:0]           tbl_dst [elt_pkg::CAPACITY];
    logic [elt_pkg::TAG_W-1:0]            tbl_tag [elt_pkg::CAPACITY];
    int                                   table_fill;
    int                                   limit_reg;

    answer_t                              awaited_answers [$];
    plan_row_t                            directed_plan [$];
    answer_t                              head_answer;

    int                                   errors;
    int                                   requests_sent;
    int                                   answers_checked;
    int                                   limit_writes;
    int                                   peak_fill;
    int                                   refused_inserts;
    int                                   misses;
    int                                   quiet_cycles;
    bit                                   tx_idle_on;
    bit                                   rx_stall_on;

    edge_list_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic edge_table_answer(input elt_pkg::req_t req,
                                     input logic [elt_pkg::NODE_W-1:0] s,
                                     input logic [elt_pkg::NODE_W-1:0] d,
                                     input logic [elt_pkg::TAG_W-1:0] t,
                                     output answer_t r);
        int lim;
        int idx;
        int i;
        lim = (limit_reg < elt_pkg::CAPACITY) ? limit_reg : elt_pkg::CAPACITY;
        r.status = elt_pkg::STAT_DONE;
        r.tag = '0;
        if (req == elt_pkg::REQ_INSERT)
        begin
            if (table_fill >= lim)
            begin
                r.status = elt_pkg::STAT_FULL;
                refused_inserts++;
            end
            else
            begin
                tbl_src[table_fill] = s;
                tbl_dst[table_fill] = d;
                tbl_tag[table_fill] = t;
                table_fill++;
            end
        end
        else
        begin
            idx = table_fill;
            for (i = table_fill - 1; i >= 0; i--)
            begin
                if (tbl_src[i] == s && tbl_dst[i] == d)
                    idx = i;
            end
            if (idx == table_fill)
            begin
                r.status = elt_pkg::STAT_NOT_FOUND;
                misses++;
            end
            else if (req == elt_pkg::REQ_CHECK)
            begin
                r.tag = tbl_tag[idx];
            end
            else if (req == elt_pkg::REQ_REMOVE)
            begin
                r.tag = tbl_tag[idx];
                for (i = idx; i < table_fill - 1; i++)
                begin
                    tbl_src[i] = tbl_src[i + 1];
                    tbl_dst[i] = tbl_dst[i + 1];
                    tbl_tag[i] = tbl_tag[i + 1];
                end
                table_fill--;
            end
            else
            begin
                tbl_tag[idx] = t;
                r.tag = t;
            end
        end
        r.count = table_fill[elt_pkg::COUNT_W-1:0];
        if (table_fill > peak_fill)
            peak_fill = table_fill;
    endtask

    task automatic add_row(input logic is_cfg, input logic [elt_pkg::LIMIT_W-1:0] cfg_val,
                           input elt_pkg::req_t req, input logic [elt_pkg::NODE_W-1:0] s,
                           input logic [elt_pkg::NODE_W-1:0] d,
                           input logic [elt_pkg::TAG_W-1:0] t,
                           input logic typed, input elt_pkg::status_t st,
                           input logic [elt_pkg::TAG_W-1:0] tag_o,
                           input logic [elt_pkg::COUNT_W-1:0] cnt);
        plan_row_t row;
        row.is_cfg     = is_cfg;
        row.cfg_val    = cfg_val;
        row.req        = req;
        row.src        = s;
        row.dst        = d;
        row.tag        = t;
        row.typed      = typed;
        row.ans.status = st;
        row.ans.tag    = tag_o;
        row.ans.count  = cnt;
        directed_plan.push_back(row);
    endtask

    task automatic send_request(input elt_pkg::req_t req,
                                input logic [elt_pkg::NODE_W-1:0] s,
                                input logic [elt_pkg::NODE_W-1:0] d,
                                input logic [elt_pkg::TAG_W-1:0] t,
                                input logic typed, input answer_t typed_ans);
        int gap;
        answer_t ans;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {t, d, s};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        edge_table_answer(req, s, d, t, ans);
        if (typed)
            awaited_answers.push_back(typed_ans);
        else
            awaited_answers.push_back(ans);
        requests_sent++;
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [elt_pkg::LIMIT_W-1:0] v);
        quiesce();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        limit_reg = v;
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [elt_pkg::NODE_W-1:0] pick_node();
        case ($urandom_range(0, 3))
            0:       return elt_pkg::NODE_W'($urandom_range(0, 3));
            1:       return elt_pkg::NODE_W'(252 + $urandom_range(0, 3));
            default: return elt_pkg::NODE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: stall counted from the moment a result shows up
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever
        begin
            stall = rx_stall_on ? $urandom_range(0, 11) : 0;
            if (stall == 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                @(posedge clk);
                while (!m_tvalid) @(posedge clk);
                repeat (stall - 1) @(posedge clk);
                m_tready <= 1'b1;
            end
            @(posedge clk);
            while (!(m_tvalid && m_tready)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("result with no request outstanding: status %0d tag %h count %0d",
                       m_tuser, m_tdata[31:0], m_tdata[38:32]);
                errors++;
            end
            else
            begin
                head_answer = awaited_answers.pop_front();
                if (m_tuser !== head_answer.status)
                begin
                    $error("status: expected %0d, got %0d", head_answer.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== head_answer.tag)
                begin
                    $error("tag_out: expected %h, got %h", head_answer.tag, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[38:32] !== head_answer.count)
                begin
                    $error("entry_count: expected %0d, got %0d", head_answer.count,
                           m_tdata[38:32]);
                    errors++;
                end
                answers_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                          k;
        int                          n;
        int                          phase;
        int                          style;
        int                          pause_at;
        int                          ins_pct;
        int                          rem_pct;
        int                          r;
        int                          pick;
        int                          random_sent;
        int                          lim;
        elt_pkg::req_t               req;
        logic [elt_pkg::NODE_W-1:0]  s;
        logic [elt_pkg::NODE_W-1:0]  d;
        logic [elt_pkg::TAG_W-1:0]   t;
        plan_row_t                   row;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        errors       = 0;
        requests_sent = 0;
        answers_checked = 0;
        limit_writes = 0;
        peak_fill    = 0;
        refused_inserts = 0;
        misses       = 0;
        tx_idle_on   = 1'b1;
        rx_stall_on  = 1'b1;
        table_fill   = 0;
        limit_reg    = elt_pkg::LIMIT_RESET;
        for (k = 0; k < elt_pkg::CAPACITY; k++)
        begin
            tbl_src[k] = '0;
            tbl_dst[k] = '0;
            tbl_tag[k] = '0;
        end

        // empty table, duplicates, first match, partial match, shift on removal
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_NOT_FOUND, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_REMOVE, 8'hff, 8'hff, 32'h0,
                1'b1, elt_pkg::STAT_NOT_FOUND, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_SET_INFO, 8'hff, 8'h00, 32'h1,
                1'b1, elt_pkg::STAT_NOT_FOUND, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'h0, 7'd1);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'hff, 8'hff, 32'hffffffff,
                1'b1, elt_pkg::STAT_DONE, 32'h0, 7'd2);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h00, 8'h00, 32'h12345678,
                1'b1, elt_pkg::STAT_DONE, 32'h0, 7'd3);
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'h0, 7'd3);
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'hff, 8'hff, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'hffffffff, 7'd3);
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'h00, 8'hff, 32'h0,
                1'b1, elt_pkg::STAT_NOT_FOUND, 32'h0, 7'd3);
        add_row(1'b0, 7'd0, elt_pkg::REQ_SET_INFO, 8'h00, 8'h00, 32'ha5a5a5a5,
                1'b1, elt_pkg::STAT_DONE, 32'ha5a5a5a5, 7'd3);
        add_row(1'b0, 7'd0, elt_pkg::REQ_REMOVE, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'ha5a5a5a5, 7'd2);
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'h12345678, 7'd2);
        add_row(1'b0, 7'd0, elt_pkg::REQ_REMOVE, 8'hff, 8'hff, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'hffffffff, 7'd1);
        // full table at limit zero, table left as it was
        add_row(1'b1, 7'd0, elt_pkg::REQ_INSERT, 8'h0, 8'h0, 32'h0,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h12, 8'h34, 32'h9abcdef0,
                1'b1, elt_pkg::STAT_FULL, 32'h0, 7'd1);
        add_row(1'b0, 7'd0, elt_pkg::REQ_CHECK, 8'h00, 8'h00, 32'h0,
                1'b1, elt_pkg::STAT_DONE, 32'h12345678, 7'd1);
        add_row(1'b1, 7'd2, elt_pkg::REQ_INSERT, 8'h0, 8'h0, 32'h0,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h5a, 8'ha5, 32'h5a5a5a5a,
                1'b1, elt_pkg::STAT_DONE, 32'h0, 7'd2);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'ha5, 8'h5a, 32'h11111111,
                1'b1, elt_pkg::STAT_FULL, 32'h0, 7'd2);
        // limit lowered below the fill
        add_row(1'b1, 7'd1, elt_pkg::REQ_INSERT, 8'h0, 8'h0, 32'h0,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h01, 8'h02, 32'h22222222,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_REMOVE, 8'h00, 8'h00, 32'h0,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h01, 8'h02, 32'h33333333,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_REMOVE, 8'h5a, 8'ha5, 32'h0,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);
        add_row(1'b0, 7'd0, elt_pkg::REQ_INSERT, 8'h01, 8'h02, 32'h44444444,
                1'b0, elt_pkg::STAT_DONE, 32'h0, 7'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k])
        begin
            row = directed_plan[k];
            if (row.is_cfg)
                write_limit(row.cfg_val);
            else
                send_request(row.req, row.src, row.dst, row.tag, row.typed, row.ans);
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (phase % 8)
                0:
                begin
                    lim = 127;
                    style = STYLE_FILL;
                end
                1:
                begin
                    lim = 64;
                    style = STYLE_MIX;
                end
                2:
                begin
                    lim = 0;
                    style = STYLE_DRAIN;
                end
                3:
                begin
                    lim = $urandom_range(2, 12);
                    style = STYLE_MIX;
                end
                4:
                begin
                    lim = 63;
                    style = STYLE_FILL;
                end
                5:
                begin
                    lim = 1;
                    style = $urandom_range(0, 2);
                end
                6:
                begin
                    lim = $urandom_range(0, 127);
                    style = $urandom_range(0, 2);
                end
                default:
                begin
                    lim = $urandom_range(20, 60);
                    style = $urandom_range(0, 2);
                end
            endcase
            case (style)
                STYLE_FILL:
                begin
                    ins_pct = 70;
                    rem_pct = 10;
                end
                STYLE_DRAIN:
                begin
                    ins_pct = 20;
                    rem_pct = 50;
                end
                default:
                begin
                    ins_pct = 40;
                    rem_pct = 25;
                end
            endcase
            write_limit(elt_pkg::LIMIT_W'(lim));
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            n = (phase == 0) ? 220 : $urandom_range(100, 180);
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            pause_at = (phase == 1 || $urandom_range(0, 2) == 0) ?
                       $urandom_range(1, n - 1) : -1;
            for (k = 0; k < n; k++)
            begin
                if (k == pause_at)
                    quiesce();
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    req = elt_pkg::REQ_INSERT;
                else if (r < ins_pct + rem_pct)
                    req = elt_pkg::REQ_REMOVE;
                else if (r[0])
                    req = elt_pkg::REQ_CHECK;
                else
                    req = elt_pkg::REQ_SET_INFO;
                // mostly hit an edge that is held, otherwise a random pair
                if (req != elt_pkg::REQ_INSERT && table_fill > 0 &&
                    $urandom_range(0, 3) != 0)
                begin
                    pick = $urandom_range(0, table_fill - 1);
                    s = tbl_src[pick];
                    d = tbl_dst[pick];
                end
                else
                begin
                    s = pick_node();
                    d = pick_node();
                end
                case ($urandom_range(0, 7))
                    0:       t = 32'h0;
                    1:       t = 32'hffffffff;
                    default: t = $urandom;
                endcase
                send_request(req, s, d, t, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        quiesce();
        repeat (elt_pkg::CAPACITY + 3 + 8) @(posedge clk);
        $display("ran %0d requests over %0d limit settings, %0d results compared",
                 requests_sent, limit_writes, answers_checked);
        $display("peak fill %0d, %0d inserts refused, %0d lookups missed",
                 peak_fill, refused_inserts, misses);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/elt_pkg.sv
sv/elt_cell.sv
sv/elt_ctrl.sv
sv/edge_list_table_unit.sv
dv/edge_list_table_unit_tb.sv
